@@ hw/rtl/spim_pkg.sv @@
`default_nettype none
package spim_pkg;

    localparam int WORD_W      = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 3;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_CPOL  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CPHA  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIV   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRM16 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_EN    = 3'd4;

    // result beat, read_word in the low bits
    typedef struct packed {
        logic              mosi_level;
        logic              sclk_level;
        logic              busy_flag;
        logic              rx_not_empty;
        logic              tx_empty;
        logic [WORD_W-1:0] read_word;
    } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/spim_skid.sv @@
`default_nettype none
module spim_skid #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/spim_core.sv @@
`default_nettype none
module spim_core #(
    parameter int MAX_FRAME_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [spim_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [spim_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                adv,
    input  wire spim_pkg::op_t                       opcode,
    input  wire logic [spim_pkg::WORD_W-1:0]         write_word,
    input  wire logic                                miso_bit,
    output spim_pkg::res_t                           res
);
    import spim_pkg::*;

    localparam int FW    = MAX_FRAME_BITS;
    localparam int EDGEW = $clog2(2 * MAX_FRAME_BITS + 1);
    localparam logic [FW-1:0] MASK8 = FW'(8'hFF);

    logic          cpol_reg, cpha_reg, frm16_reg, en_reg;
    logic [2:0]    div_reg;

    logic [FW-1:0]    txh_reg, txh_next;
    logic             txf_reg, txf_next;
    logic [FW-1:0]    sh_reg, sh_next;
    logic [FW-1:0]    rxh_reg, rxh_next;
    logic             rxf_reg, rxf_next;
    logic [EDGEW-1:0] edge_reg, edge_next;
    logic [7:0]       tdiv_reg, tdiv_next;
    logic             clk_reg, clk_next;
    logic             act_reg, act_next;
    logic             smp_reg, smp_next;

    logic [FW-1:0]    mask;
    logic [EDGEW-1:0] last_edge;
    logic [8:0]       half;
    logic             odd, last;
    logic [WORD_W-1:0] rd;

    assign mask      = frm16_reg ? {FW{1'b1}} : MASK8;
    assign last_edge = frm16_reg ? EDGEW'(2 * MAX_FRAME_BITS) : EDGEW'(16);
    assign half      = 9'd1 << div_reg;

    always_comb begin
        txh_next  = txh_reg;
        txf_next  = txf_reg;
        sh_next   = sh_reg;
        rxh_next  = rxh_reg;
        rxf_next  = rxf_reg;
        edge_next = edge_reg;
        tdiv_next = tdiv_reg;
        clk_next  = clk_reg;
        act_next  = act_reg;
        smp_next  = smp_reg;
        odd       = 1'b0;
        last      = 1'b0;
        rd        = '0;
        case (opcode)
            OP_TICK: begin
                if (!en_reg) begin
                    act_next  = 1'b0;
                    edge_next = '0;
                    tdiv_next = '0;
                    clk_next  = cpol_reg;
                end else if (!act_reg) begin
                    clk_next = cpol_reg;
                    if (txf_reg) begin
                        sh_next   = txh_reg & mask;
                        txf_next  = 1'b0;
                        act_next  = 1'b1;
                        edge_next = '0;
                        tdiv_next = '0;
                        smp_next  = 1'b0;
                    end
                end else if ({1'b0, tdiv_reg} + 9'd1 >= half) begin
                    // serial clock edge
                    tdiv_next = '0;
                    edge_next = edge_reg + EDGEW'(1);
                    clk_next  = !clk_reg;
                    odd       = edge_next[0];
                    last      = edge_next >= last_edge;
                    if (cpha_reg ? !odd : odd) begin
                        smp_next = miso_bit;
                    end
                    if (cpha_reg ? ((odd && edge_next > EDGEW'(1)) || last) : !odd) begin
                        sh_next = {sh_reg[FW-2:0], smp_next};
                    end
                    if (last) begin
                        rxh_next  = sh_next & mask;
                        rxf_next  = 1'b1;
                        act_next  = 1'b0;
                        edge_next = '0;
                        clk_next  = cpol_reg;
                    end
                end else begin
                    tdiv_next = tdiv_reg + 8'd1;
                end
            end
            OP_WRITE: begin
                txh_next = write_word[FW-1:0] & mask;
                txf_next = 1'b1;
            end
            OP_READ: begin
                rd       = WORD_W'(rxh_reg);
                rxf_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        res.read_word    = rd;
        res.tx_empty     = !txf_next;
        res.rx_not_empty = rxf_next;
        res.busy_flag    = act_next;
        res.sclk_level   = clk_next;
        res.mosi_level   = act_next && (frm16_reg ? sh_next[FW-1] : sh_next[7]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpol_reg  <= 1'b0;
            cpha_reg  <= 1'b0;
            div_reg   <= '0;
            frm16_reg <= 1'b0;
            en_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CPOL:  cpol_reg  <= cfg_wdata[0];
                CFG_CPHA:  cpha_reg  <= cfg_wdata[0];
                CFG_DIV:   div_reg   <= cfg_wdata[2:0];
                CFG_FRM16: frm16_reg <= cfg_wdata[0];
                CFG_EN:    en_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txh_reg  <= '0;
            txf_reg  <= 1'b0;
            sh_reg   <= '0;
            rxh_reg  <= '0;
            rxf_reg  <= 1'b0;
            edge_reg <= '0;
            tdiv_reg <= '0;
            clk_reg  <= 1'b0;
            act_reg  <= 1'b0;
            smp_reg  <= 1'b0;
        end else if (adv) begin
            txh_reg  <= txh_next;
            txf_reg  <= txf_next;
            sh_reg   <= sh_next;
            rxh_reg  <= rxh_next;
            rxf_reg  <= rxf_next;
            edge_reg <= edge_next;
            tdiv_reg <= tdiv_next;
            clk_reg  <= clk_next;
            act_reg  <= act_next;
            smp_reg  <= smp_next;
        end else if (cfg_wr_en && !act_reg && (cfg_addr inside {[CFG_CPOL:CFG_EN]})) begin
            // idle clock line follows polarity
            clk_reg <= (cfg_addr == CFG_CPOL) ? cfg_wdata[0] : cpol_reg;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/spi_master_controller.sv @@
// SPI master controller, driver view.
// Input stream (s_axis_*): one beat per bus access or peripheral tick:
//   opcode 0 tick, 1 write data register, 2 read data register, 3 read status.
// Result stream (m_axis_*): exactly one beat per input beat, in order, with
//   read data (reads only, else zero), buffer flags, busy, SCLK and MOSI levels.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata, write-only, one register per
//   cycle: 0 CPOL, 1 CPHA, 2 divider code, 3 16-bit frames, 4 enable.
//   Write only while no beat is in flight.
// Throughput: one beat per cycle sustained while m_axis_tready stays
//   high. An accepted beat sits in the input register while the update
//   logic computes the new state; the result is then registered into the
//   output register, or into the skid register while the output is held,
//   and leaves from there.
// Stall: a skid stage behind the output register keeps s_axis_tready high
//   for one extra beat after m_axis_tready drops; then the input holds.
// Reset (aresetn low, synchronous): config, buffers, shifter and flags
//   clear, SCLK idles low, both streams empty.
// Serial timing: one SCLK edge every 2^divider_code ticks, MSB first.
`default_nettype none
module spi_master_controller #(
    parameter int MAX_FRAME_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // config write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [spim_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [spim_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input beats
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [1:0] opcode, [17:2] write_word, [18] miso_bit, [23:19] zero
    input  wire logic [spim_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result beats
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [15:0] read_word, [16] tx_empty, [17] rx_not_empty, [18] busy_flag,
    // [19] sclk_level, [20] mosi_level, [23:21] zero
    output logic      [spim_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import spim_pkg::*;

    localparam int RES_W = $bits(res_t);

    // input register
    logic              in_vld_reg;
    op_t               op_reg;
    logic [WORD_W-1:0] word_reg;
    logic              miso_reg;

    logic              sk_ready;
    logic              adv;
    res_t              res;
    logic [RES_W-1:0]  out_res;

    assign adv           = in_vld_reg && sk_ready;
    assign s_axis_tready = !in_vld_reg || sk_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg   <= op_t'(s_axis_tdata[1:0]);
            word_reg <= s_axis_tdata[17:2];
            miso_reg <= s_axis_tdata[18];
        end
    end

    // state update; commits when the beat moves to the output side
    spim_core #(
        .MAX_FRAME_BITS(MAX_FRAME_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .adv        (adv),
        .opcode     (op_reg),
        .write_word (word_reg),
        .miso_bit   (miso_reg),
        .res        (res)
    );

    // result register plus skid
    spim_skid #(
        .DATA_W(RES_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_vld_reg),
        .in_ready  (sk_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), out_res};

    // a data write always leaves the transmit buffer full
    a_write_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && op_reg == OP_WRITE |-> !res.tx_empty)
        else $error("tx_empty set after data write");

    // read data only on data reads
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && op_reg != OP_READ |-> res.read_word == '0)
        else $error("read_word nonzero on non-read beat");

    // MOSI idles low when no frame is shifting
    a_mosi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !res.busy_flag |-> !res.mosi_level)
        else $error("mosi high while not busy");

    // a held input beat is not lost while the output side is full
    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !sk_ready |=> in_vld_reg && $stable(word_reg))
        else $error("input beat dropped under stall");

endmodule
`default_nettype wire

@@ sim/spim_result_checker.sv @@
// Watches both streams and the config port, tracks the SPI controller state
// and compares every result beat against the predicted one.
module spim_result_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [spim_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [spim_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [spim_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [spim_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output int unsigned                        beats_outstanding,
    output int unsigned                        mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import spim_pkg::*;

    localparam int unsigned PRINT_CAP = 100;

    // port settings
    logic        cpol, cpha, frm16, port_on;
    logic [2:0]  div_code;

    // controller state
    logic [15:0] tx_hold, shifter, rx_hold;
    logic        tx_full, rx_full, running, sclk_q, miso_held;
    logic [5:0]  edge_cnt;
    logic [7:0]  tick_cnt;

    res_t        expected_res_q[$];
    int unsigned beat_no;

    function automatic int unsigned frame_len();
        return frm16 ? 16 : 8;
    endfunction

    function automatic logic [15:0] frame_mask();
        return frm16 ? 16'hFFFF : 16'h00FF;
    endfunction

    task automatic clear_state();
        cpol = 1'b0; cpha = 1'b0; frm16 = 1'b0; port_on = 1'b0; div_code = '0;
        tx_hold = '0; shifter = '0; rx_hold = '0;
        tx_full = 1'b0; rx_full = 1'b0; miso_held = 1'b0;
        running = 1'b0; edge_cnt = '0; tick_cnt = '0; sclk_q = 1'b0;
    endtask

    task automatic drop_frame();
        running  = 1'b0;
        edge_cnt = '0;
        tick_cnt = '0;
        sclk_q   = cpol;
    endtask

    task automatic toggle_sclk(input logic miso);
        logic odd, done;
        edge_cnt = edge_cnt + 6'd1;
        sclk_q   = ~sclk_q;
        odd      = edge_cnt[0];
        done     = (edge_cnt >= 2 * frame_len());
        if (cpha ? !odd : odd)
            miso_held = miso;
        // CPHA=1 shifts on odd edges past the first, plus once on the last edge
        if (cpha ? ((odd && edge_cnt > 6'd1) || done) : !odd)
            shifter = {shifter[14:0], miso_held};
        if (done) begin
            rx_hold = shifter & frame_mask();
            rx_full = 1'b1;
            drop_frame();
        end
    endtask

    task automatic advance_tick(input logic miso);
        int unsigned half_period;
        half_period = 1 << div_code;
        if (!port_on) begin
            drop_frame();
        end else if (!running) begin
            sclk_q = cpol;
            if (tx_full) begin
                shifter   = tx_hold & frame_mask();
                tx_full   = 1'b0;
                running   = 1'b1;
                edge_cnt  = '0;
                tick_cnt  = '0;
                miso_held = 1'b0;
            end
        end else if (tick_cnt + 1 >= half_period) begin
            tick_cnt = '0;
            toggle_sclk(miso);
        end else begin
            tick_cnt = tick_cnt + 8'd1;
        end
    endtask

    task automatic apply_cfg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_CPOL:  cpol     = data[0];
            CFG_CPHA:  cpha     = data[0];
            CFG_DIV:   div_code = data[2:0];
            CFG_FRM16: frm16    = data[0];
            CFG_EN:    port_on  = data[0];
            default:   return;
        endcase
        if (!running)
            sclk_q = cpol;
    endtask

    task automatic predict_access(input op_t op, input logic [15:0] word,
                                  input logic miso, output res_t res);
        res = '0;
        case (op)
            OP_TICK:   advance_tick(miso);
            OP_WRITE: begin
                tx_hold = word & frame_mask();
                tx_full = 1'b1;
            end
            OP_READ: begin
                res.read_word = rx_hold;
                rx_full       = 1'b0;
            end
            OP_STATUS: ;
        endcase
        res.tx_empty     = !tx_full;
        res.rx_not_empty = rx_full;
        res.busy_flag    = running;
        res.sclk_level   = sclk_q;
        res.mosi_level   = running ? shifter[frame_len() - 1] : 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] result beat %0d: %s got 0x%0h, expected 0x%0h",
                     $realtime, beat_no, what, got, want);
        mismatch_count++;
    endtask

    initial begin
        mismatch_count = 0;
        beat_no = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        res_t got, want;
        res_t res;
        if (!aresetn) begin
            clear_state();
            expected_res_q.delete();
            beats_outstanding <= 0;
        end else begin
            if (cfg_wr_en)
                apply_cfg(cfg_addr, cfg_wdata);
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(res_t)-1:0];
                if (expected_res_q.size() == 0) begin
                    report_mismatch("beat with nothing expected", got, 0);
                end else begin
                    want = expected_res_q.pop_front();
                    if (got.read_word !== want.read_word)
                        report_mismatch("read_word", got.read_word, want.read_word);
                    if (got.tx_empty !== want.tx_empty)
                        report_mismatch("tx_empty", got.tx_empty, want.tx_empty);
                    if (got.rx_not_empty !== want.rx_not_empty)
                        report_mismatch("rx_not_empty", got.rx_not_empty, want.rx_not_empty);
                    if (got.busy_flag !== want.busy_flag)
                        report_mismatch("busy_flag", got.busy_flag, want.busy_flag);
                    if (got.sclk_level !== want.sclk_level)
                        report_mismatch("sclk_level", got.sclk_level, want.sclk_level);
                    if (got.mosi_level !== want.mosi_level)
                        report_mismatch("mosi_level", got.mosi_level, want.mosi_level);
                end
                beat_no++;
            end
            if (s_tvalid && s_tready) begin
                predict_access(op_t'(s_tdata[1:0]), s_tdata[17:2], s_tdata[18], res);
                expected_res_q.push_back(res);
            end
            beats_outstanding <= expected_res_q.size();
        end
    end

endmodule

@@ sim/tb_spi_master_controller.sv @@
// Top of the SPI master controller bench: clock, reset, config writes,
// input beats and result-side backpressure. All result checking lives in
// spim_result_checker; this module only drives and gives the verdict.
module tb_spi_master_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import spim_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400_000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;  // long sink stall, fills the pipe
    localparam int unsigned SETTLE_CYCLES   = 10;   // covers input register, output register and skid stage
    localparam int          NUM_PLANNED     = 10;
    localparam int          NUM_PHASES      = 14;
    localparam int          HOLD_PHASE      = 9;
    localparam int unsigned FIRST_UNUSED    = CFG_EN + 1;
    localparam int unsigned LAST_ADDR       = (1 << CFG_ADDR_W) - 1;

    // one full set of port settings
    typedef struct packed {
        logic       cpol;
        logic       cpha;
        logic [2:0] div;
        logic       frm16;
        logic       en;
    } port_cfg_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_axis_tvalid, s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid, m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned beats_outstanding, mismatch_count;
    int unsigned cycle_count = 0;

    // pacing knobs, set per phase by the stimulus process
    int unsigned items_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned gap_max      = 0;  // 0: sender never idles
    int unsigned rx_stall_pct = 0;  // 0: no random sink stalls
    int unsigned rx_stall_max = 1;
    logic        hold_off_req = 1'b0;
    port_cfg_t   port_now;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    spi_master_controller dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    spim_result_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_tvalid          (s_axis_tvalid),
        .s_tready          (s_axis_tready),
        .s_tdata           (s_axis_tdata),
        .m_tvalid          (m_axis_tvalid),
        .m_tready          (m_axis_tready),
        .m_tdata           (m_axis_tdata),
        .beats_outstanding (beats_outstanding),
        .mismatch_count    (mismatch_count)
    );

    // hard stop if the bench hangs (lost beat, stuck tready, ...)
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** spi_master_controller: FAILED **");
            $finish;
        end
    end

    // Result sink. Random stall runs per phase settings; on request it holds
    // tready low for a long stretch, counted here, while the sender keeps
    // offering beats so the block backs up into s_axis_tready.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_pct != 0 && $urandom_range(99, 0) < rx_stall_pct) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(rx_stall_max, 1) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // One config register write per cycle; caller lowers the enable.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Writes every register, plus one unmapped index that must be ignored.
    // Unused upper data bits of the 1-bit registers get random junk.
    task automatic program_port(input port_cfg_t c);
        logic [CFG_DATA_W-2:0] pad;
        port_now = c;
        pad = (CFG_DATA_W-1)'($urandom);
        cfg_write(CFG_CPOL,  {pad, c.cpol});
        pad = (CFG_DATA_W-1)'($urandom);
        cfg_write(CFG_CPHA,  {pad, c.cpha});
        cfg_write(CFG_DIV,   c.div);
        pad = (CFG_DATA_W-1)'($urandom);
        cfg_write(CFG_FRM16, {pad, c.frm16});
        pad = (CFG_DATA_W-1)'($urandom);
        cfg_write(CFG_EN,    {pad, c.en});
        cfg_write(CFG_ADDR_W'($urandom_range(LAST_ADDR, FIRST_UNUSED)), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one beat and wait for the handshake. Bursts of random length,
    // random gaps between them when gap_max is nonzero.
    task automatic send_access(input op_t op, input logic [15:0] word, input logic miso);
        if (burst_left == 0) begin
            if (gap_max != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(posedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        // [1:0] opcode, [17:2] write_word, [18] miso_bit, rest zero
        s_axis_tdata  <= {5'b0, miso, word, op};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering, wait for every predicted result, then let the pipe settle
    // so a config write cannot land on a beat in flight.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (beats_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Well-formed transfer: load the tx buffer, tick it through a whole frame
    // (start tick + 2*bits edges, each 2^div ticks apart) with random MISO,
    // then pick up the received word. Occasional stray accesses mid-frame
    // and a second write while the buffer is still full.
    task automatic run_transfer(input int unsigned stop_at);
        int unsigned n_ticks;
        n_ticks = 2 * (port_now.frm16 ? 16 : 8) * (1 << port_now.div) + 1
                  + $urandom_range(3, 0);
        send_access(OP_WRITE, 16'($urandom), 1'($urandom));
        if ($urandom_range(9, 0) == 0 && items_sent < stop_at)
            send_access(OP_WRITE, 16'($urandom), 1'($urandom));
        for (int i = 0; i < n_ticks && items_sent < stop_at; i++) begin
            if ($urandom_range(7, 0) == 0)
                send_access(op_t'($urandom_range(OP_STATUS, OP_WRITE)),
                            16'($urandom), 1'($urandom));
            else
                send_access(OP_TICK, 16'($urandom), 1'($urandom));
        end
        // skipping the data read now and then lets the next frame overwrite
        if (items_sent < stop_at)
            send_access(($urandom_range(3, 0) != 0) ? OP_READ : OP_STATUS,
                        16'($urandom), 1'($urandom));
    endtask

    // Runs until the beat budget is spent; the last transfer usually breaks
    // off mid-frame, so the next phase's config lands on a running frame.
    task automatic run_phase(input int unsigned budget);
        int unsigned stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(9, 0) < 8) begin
                run_transfer(stop_at);
            end else begin
                repeat ($urandom_range(8, 1))
                    send_access(op_t'($urandom_range(OP_STATUS, OP_TICK)),
                                16'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        port_cfg_t   plan [NUM_PLANNED];
        int unsigned plan_len [NUM_PLANNED];
        port_cfg_t   c;
        int unsigned budget;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // Consecutive phases differ in one or more settings so that each
        // change hits a frame in flight: polarity, phase, size (16 -> 8),
        // divider up and down, and enable dropped mid-frame.
        //            cpol  cpha  div   frm16 en
        plan = '{'{1'b0, 1'b0, 3'd0, 1'b0, 1'b1},
                 '{1'b1, 1'b0, 3'd0, 1'b0, 1'b1},
                 '{1'b1, 1'b1, 3'd0, 1'b1, 1'b1},
                 '{1'b1, 1'b1, 3'd0, 1'b0, 1'b1},
                 '{1'b0, 1'b1, 3'd1, 1'b0, 1'b1},
                 '{1'b0, 1'b0, 3'd2, 1'b1, 1'b1},
                 '{1'b0, 1'b0, 3'd2, 1'b1, 1'b0},
                 '{1'b1, 1'b0, 3'd7, 1'b0, 1'b1},
                 '{1'b1, 1'b0, 3'd1, 1'b0, 1'b1},
                 '{1'b0, 1'b1, 3'd0, 1'b1, 1'b1}};
        // slowest divider gets one partial frame only
        plan_len = '{150, 150, 150, 120, 150, 150, 40, 300, 120, 150};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_PLANNED) begin
                c      = plan[p];
                budget = plan_len[p];
            end else begin
                c.cpol  = 1'($urandom);
                c.cpha  = 1'($urandom);
                c.div   = 3'($urandom_range(3, 0));
                c.frm16 = 1'($urandom);
                c.en    = ($urandom_range(7, 0) != 0);
                budget  = 100;
            end
            program_port(c);

            // idle mix rotates: none, light, heavy
            case (p % 3)
                0: begin
                    gap_max = 0; rx_stall_pct = 0; rx_stall_max = 1;
                end
                1: begin
                    gap_max = 3; rx_stall_pct = 20; rx_stall_max = 3;
                end
                default: begin
                    gap_max = 8; rx_stall_pct = 40; rx_stall_max = 10;
                end
            endcase
            if (p == HOLD_PHASE) begin
                gap_max = 0;
                hold_off_req = 1'b1;
            end

            if (p == 0) begin
                // 8-bit mode 0, divide by 2: one edge per tick
                send_access(OP_STATUS, 16'h0000, 1'b0);
                send_access(OP_READ,   16'hFFFF, 1'b1);  // nothing received yet
                send_access(OP_WRITE,  16'hFFFF, 1'b0);  // masked to the low byte
                send_access(OP_WRITE,  16'h5AA5, 1'b1);  // overwrite of a full buffer
                for (int i = 0; i < 17; i++)             // start tick, then every edge of the frame
                    send_access(OP_TICK, 16'h0000, i[0] ^ i[2]);
                send_access(OP_READ,   16'h0000, 1'b0);  // received word, flag clears
                send_access(OP_READ,   16'h0000, 1'b1);  // stale word, flag stays clear
                send_access(OP_STATUS, 16'hFFFF, 1'b1);
            end

            run_phase(budget);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("** spi_master_controller: PASSED **");
        else
            $display("** spi_master_controller: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/spim_pkg.sv
hw/rtl/spim_skid.sv
hw/rtl/spim_core.sv
hw/rtl/spi_master_controller.sv
sim/spim_result_checker.sv
sim/tb_spi_master_controller.sv
